### rtl/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
`timescale 1ns / 1ps

package uer_pkg;

    localparam int TIME_W  = 32;
    localparam int DIST_W  = 26;
    localparam int CFG_W   = 16;
    localparam int WAIT_W  = 17;
    localparam int QUOT_W  = TIME_W - 2;
    localparam int RECIP_W = 31;
    localparam int PROD_W  = QUOT_W + RECIP_W;
    localparam int RECIP_SHIFT = 35;

    // ceil(2^35 / 29), exact for any 30-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_29 = 31'd1184818565;

    localparam logic [WAIT_W-1:0] WAIT_MAX      = '1;
    localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 16'd8000;
    localparam logic [CFG_W-1:0]  RANGE_RESET   = 16'd300;

    typedef enum logic [0:0] {
        REG_TIMEOUT   = 1'b0,
        REG_MAX_RANGE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEND = 3'd1,
        PH_STOP = 3'd2,
        PH_RISE = 3'd3,
        PH_FALL = 3'd4
    } phase_t;

    typedef struct packed {
        logic              trig;
        logic              done;
        logic              tout;
        logic [TIME_W-1:0] echo_time;
    } item_t;

endpackage

### rtl/uer_seq.sv
// ranging sequencer with its first pipeline register
`timescale 1ns / 1ps

module uer_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           echo_level,
    input  logic [uer_pkg::TIME_W-1:0]     time_us,
    input  logic [uer_pkg::CFG_W-1:0]      timeout_ticks,
    output logic                           s1_valid,
    input  logic                           s1_ready,
    output uer_pkg::item_t                 s1_item
);
    import uer_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  held_reg, held_next;
    logic               trig_reg, trig_next;
    logic               done, tout;
    logic [WAIT_W-1:0]  wait_bump;
    logic               limit_hit;
    logic               accept;
    logic               v1_reg;
    item_t              item1_reg;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !v1_reg || s1_ready;
    assign wait_bump = (wait_reg == WAIT_MAX) ? wait_reg : wait_reg + 1'b1;
    assign limit_hit = wait_bump > {1'b0, timeout_ticks};

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        start_next = start_reg;
        held_next  = held_reg;
        trig_next  = trig_reg;
        done       = 1'b0;
        tout       = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                trig_next  = 1'b0;
                phase_next = PH_SEND;
            end
            PH_SEND:
            begin
                trig_next  = 1'b1;
                phase_next = PH_STOP;
            end
            PH_STOP:
            begin
                trig_next  = 1'b0;
                wait_next  = '0;
                phase_next = PH_RISE;
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    start_next = time_us;
                    phase_next = PH_FALL;
                end
                wait_next = wait_bump;
                if (limit_hit)
                begin
                    phase_next = PH_IDLE;
                    tout       = 1'b1;
                end
            end
            PH_FALL:
            begin
                if (!echo_level)
                begin
                    held_next  = time_us - start_reg;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                wait_next = wait_bump;
                if (limit_hit)
                begin
                    phase_next = PH_IDLE;
                    tout       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            start_reg <= '0;
            held_reg  <= '0;
            trig_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            start_reg <= start_next;
            held_reg  <= held_next;
            trig_reg  <= trig_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (in_ready)
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item1_reg.trig      <= trig_next;
            item1_reg.done      <= done;
            item1_reg.tout      <= tout;
            item1_reg.echo_time <= held_next;
        end
    end

    assign s1_valid = v1_reg;
    assign s1_item  = item1_reg;

endmodule

### rtl/uer_div.sv
// distance stage: echo time divided by 116 through a reciprocal multiply
`timescale 1ns / 1ps

module uer_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    output logic                           s1_ready,
    input  uer_pkg::item_t                 s1_item,
    output logic                           s2_valid,
    input  logic                           s2_ready,
    output uer_pkg::item_t                 s2_item,
    output logic [uer_pkg::DIST_W-1:0]     s2_dist
);
    import uer_pkg::*;

    logic [QUOT_W-1:0] quot4;
    logic [PROD_W-1:0] prod;
    logic              v2_reg;
    item_t             item2_reg;
    logic [DIST_W-1:0] dist_reg;

    // divide by 4 first, then by 29
    assign quot4    = s1_item.echo_time[TIME_W-1:2];
    assign prod     = PROD_W'(quot4) * PROD_W'(RECIP_29);
    assign s1_ready = !v2_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (s1_ready)
            v2_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            item2_reg <= s1_item;
            dist_reg  <= prod[RECIP_SHIFT +: DIST_W];
        end
    end

    assign s2_valid = v2_reg;
    assign s2_item  = item2_reg;
    assign s2_dist  = dist_reg;

endmodule

### rtl/uer_out.sv
// output register with the range check
`timescale 1ns / 1ps

module uer_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s2_valid,
    output logic                           s2_ready,
    input  uer_pkg::item_t                 s2_item,
    input  logic [uer_pkg::DIST_W-1:0]     s2_dist,
    input  logic [uer_pkg::CFG_W-1:0]      max_range_cm,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           trigger_level,
    output logic                           measurement_done,
    output logic                           timed_out,
    output logic [uer_pkg::TIME_W-1:0]     echo_time_us,
    output logic [uer_pkg::DIST_W-1:0]     distance_cm,
    output logic                           in_range
);
    import uer_pkg::*;

    logic              v3_reg;
    item_t             item3_reg;
    logic [DIST_W-1:0] dist3_reg;
    logic              range3_reg;
    logic              range_ok;

    assign range_ok = (s2_dist != '0) && (s2_dist < DIST_W'(max_range_cm));
    assign s2_ready = !v3_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (s2_ready)
            v3_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s2_valid)
        begin
            item3_reg  <= s2_item;
            dist3_reg  <= s2_dist;
            range3_reg <= range_ok;
        end
    end

    assign out_valid        = v3_reg;
    assign trigger_level    = item3_reg.trig;
    assign measurement_done = item3_reg.done;
    assign timed_out        = item3_reg.tout;
    assign echo_time_us     = item3_reg.echo_time;
    assign distance_cm      = dist3_reg;
    assign in_range         = range3_reg;

endmodule

### rtl/ultrasonic_echo_ranger_top.sv
// top level of the ultrasonic echo ranger
`timescale 1ns / 1ps

// usage
// the input channel takes one timer tick per transaction: echo_level is the
// sampled echo pin and time_us the free-running microsecond timestamp
// every input transaction yields exactly one output transaction: trigger
// level, done and timeout flags, the held echo time, distance and range flag
// throughput: one tick per cycle unless back-pressure from out_ready stalls it;
// the sequencer step, the multiply by the reciprocal of 29 and the range
// compare each take one register stage
// configuration: cfg_index 0 is timeout_ticks, 1 is max_range_cm, written on
// any edge with cfg_wr_en high, to be used only while the block is idle
// reset: sequencer to idle phase, held time to zero, distance registers not
// reset, registers to 8000 ticks and 300 cm, pipeline empty
// stall: with out_ready low the pipeline fills and in_ready drops once all
// three stages hold a transaction; nothing is lost or repeated
module ultrasonic_echo_ranger_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           echo_level,
    input  logic [uer_pkg::TIME_W-1:0]     time_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           trigger_level,
    output logic                           measurement_done,
    output logic                           timed_out,
    output logic [uer_pkg::TIME_W-1:0]     echo_time_us,
    output logic [uer_pkg::DIST_W-1:0]     distance_cm,
    output logic                           in_range,
    input  logic                           cfg_wr_en,
    input  uer_pkg::cfg_idx_t              cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]      cfg_wdata
);
    import uer_pkg::*;

    logic [CFG_W-1:0]  timeout_reg;
    logic [CFG_W-1:0]  range_reg;
    logic              s1_valid, s1_ready;
    item_t             s1_item;
    logic              s2_valid, s2_ready;
    item_t             s2_item;
    logic [DIST_W-1:0] s2_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            range_reg   <= RANGE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:   timeout_reg <= cfg_wdata;
                REG_MAX_RANGE: range_reg   <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    uer_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .echo_level    (echo_level),
        .time_us       (time_us),
        .timeout_ticks (timeout_reg),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_item       (s1_item)
    );

    uer_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_item  (s1_item),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_item  (s2_item),
        .s2_dist  (s2_dist)
    );

    uer_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .s2_valid         (s2_valid),
        .s2_ready         (s2_ready),
        .s2_item          (s2_item),
        .s2_dist          (s2_dist),
        .max_range_cm     (range_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .trigger_level    (trigger_level),
        .measurement_done (measurement_done),
        .timed_out        (timed_out),
        .echo_time_us     (echo_time_us),
        .distance_cm      (distance_cm),
        .in_range         (in_range)
    );

    // the trigger pulse tick never carries a result or a timeout
    a_trig_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_level |-> !measurement_done && !timed_out)
        else $error("trigger pulse coincides with a result flag");

    // a zero distance is never in range
    a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> distance_cm != '0)
        else $error("zero distance reported in range");

    // back-pressure on the input only comes from a full pipeline
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && s1_valid && s2_valid)
        else $error("input stalled with room in the pipeline");

endmodule
